// ===== rtl/core/resp_reply_framer_unit_macros.svh =====
// Assertion macros for the reply framer checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef RESP_REPLY_FRAMER_UNIT_MACROS_SVH
`define RESP_REPLY_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reply framer check failed");

// Next-cycle implication, disabled in reset.
`define RRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reply framer check failed");

`endif

// ===== rtl/core/rrf_pkg.sv =====
// Shared types and constants for the reply framer.
// No dependencies; used by the channel interface users, top level and checker.
package rrf_pkg;

  localparam int CFG_W    = 21;
  localparam int LEN_W    = 21;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 3;

  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 21'h1FFFFF;

  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_PLUS   = 8'h2B;
  localparam logic [7:0] CHR_MINUS  = 8'h2D;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_0      = 8'h30;
  localparam logic [7:0] CHR_9      = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_BAD_NUM   = 3'd2,
    ST_NO_DOLLAR = 3'd3,
    ST_NIL_ELEM  = 3'd4,
    ST_NO_CRLF   = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS  = 3'd0,
    KIND_ERROR   = 3'd1,
    KIND_INTEGER = 3'd2,
    KIND_BULK    = 3'd3,
    KIND_ARRAY   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    frame_length;
    logic [KIND_W-1:0]   reply_kind;
  } out_word_t;

  typedef logic [CFG_W-1:0] cfg_word_t;

endpackage

// ===== rtl/core/rrf_chan_if.sv =====
// Valid/ready channel carrying one word of type T.
// No dependencies; T is set per instance from rrf_pkg types.
interface rrf_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/resp_reply_framer_unit.sv =====
// Reply framer: one byte per clock, result word registered from the byte that
// ends (or breaks) a frame; throughput one byte per clock while the output
// side keeps up, set by the single-pass parser step on the state regs.
// A two-word output buffer lets bytes keep flowing while one result waits.
// Reset (rst, synchronous): parser idle, max_frame_len = 2097151, buffer empty.
module resp_reply_framer_unit #(
  parameter int NUM_BITS       = 32,
  parameter int FRAME_LEN_BITS = 21
) (
  input  logic           clk,
  input  logic           rst,
  rrf_chan_if.sink       bytes,
  rrf_chan_if.source     frames,
  rrf_chan_if.sink       cfg
);

  // Widths for the limit comparisons
  localparam int VW = NUM_BITS + 4;   // holds value*10 + digit
  localparam int NW = (NUM_BITS > rrf_pkg::CFG_W) ? NUM_BITS : rrf_pkg::CFG_W;
  localparam int LW = (FRAME_LEN_BITS > rrf_pkg::CFG_W) ? FRAME_LEN_BITS : rrf_pkg::CFG_W;
  localparam logic [NW-1:0] NUM_LIM   = NW'((64'd1 << NUM_BITS) - 64'd2);
  localparam logic [LW-1:0] FRAME_LIM = LW'((64'd1 << FRAME_LEN_BITS) - 64'd1);

  // Parser phases, one-hot
  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_LINE      = 10'b00_0000_0010,
    PH_LINE_LF   = 10'b00_0000_0100,
    PH_HDR0      = 10'b00_0000_1000,
    PH_HDR       = 10'b00_0001_0000,
    PH_HDR_LF    = 10'b00_0010_0000,
    PH_ELEM_TYPE = 10'b00_0100_0000,
    PH_PAYLOAD   = 10'b00_1000_0000,
    PH_DATA_CR   = 10'b01_0000_0000,
    PH_DATA_LF   = 10'b10_0000_0000
  } phase_t;

  // Parser state
  phase_t                      phase, phase_next;
  rrf_pkg::kind_t              cur_kind, cur_kind_next;
  logic                        neg_sign, neg_sign_next;
  logic [NUM_BITS-1:0]         num_value, num_value_next;
  logic                        digits_seen, digits_seen_next;
  logic [NUM_BITS-1:0]         payload_left, payload_left_next;
  logic [NUM_BITS-1:0]         elems_left, elems_left_next;
  logic [FRAME_LEN_BITS-1:0]   byte_cnt, byte_cnt_next;
  rrf_pkg::cfg_word_t          max_frame_len;

  // Output register plus skid word
  rrf_pkg::out_word_t          out_word, skid_word;
  logic                        out_valid, skid_valid;

  // Step result
  rrf_pkg::out_word_t          res;
  logic                        res_valid;

  // Limits from the register
  logic [NW-1:0]               nlim_w;
  logic [NUM_BITS-1:0]         nlim;
  logic [LW-1:0]               llim_w;
  logic [FRAME_LEN_BITS-1:0]   llim;

  logic                        accept, push, pop;

  always_comb begin
    nlim_w = (NW'(max_frame_len) < NUM_LIM) ? NW'(max_frame_len) : NUM_LIM;
    nlim   = nlim_w[NUM_BITS-1:0];
    llim_w = (LW'(max_frame_len) < FRAME_LIM) ? LW'(max_frame_len) : FRAME_LIM;
    llim   = llim_w[FRAME_LEN_BITS-1:0];
  end

  assign accept = bytes.valid && bytes.ready;
  assign push   = accept && res_valid;
  assign pop    = out_valid && frames.ready;

  // Single-pass parser step on one byte
  always_comb begin
    phase_t                  p;
    rrf_pkg::kind_t          k;
    logic                    ng;
    logic [NUM_BITS-1:0]     nv;
    logic                    dg;
    logic [NUM_BITS-1:0]     pl;
    logic [NUM_BITS-1:0]     el;
    logic [FRAME_LEN_BITS-1:0] bc;
    logic [FRAME_LEN_BITS:0] cnt;
    logic [7:0]              b;
    logic [7:0]              dig8;
    logic [VW-1:0]           v;
    logic                    is_digit;
    logic                    fail, done;
    rrf_pkg::status_t        code;
    logic [LW-1:0]           len_w;

    b    = bytes.data.data_byte;
    // restart discards the partial frame before this byte is looked at
    p  = phase;  k  = cur_kind; ng = neg_sign; nv = num_value; dg = digits_seen;
    pl = payload_left; el = elems_left; bc = byte_cnt;
    if (bytes.data.restart) begin
      p  = PH_IDLE; k = rrf_pkg::KIND_STATUS; ng = 1'b0; nv = '0; dg = 1'b0;
      pl = '0; el = '0; bc = '0;
    end

    phase_next        = p;
    cur_kind_next     = k;
    neg_sign_next     = ng;
    num_value_next    = nv;
    digits_seen_next  = dg;
    payload_left_next = pl;
    elems_left_next   = el;
    byte_cnt_next     = bc;
    fail = 1'b0;
    done = 1'b0;
    code = rrf_pkg::ST_OK;

    dig8     = b - rrf_pkg::CHR_0;
    is_digit = (b >= rrf_pkg::CHR_0) && (b <= rrf_pkg::CHR_9);
    v        = (VW'(nv) << 3) + (VW'(nv) << 1) + VW'(dig8[3:0]);
    cnt      = {1'b0, bc} + (FRAME_LEN_BITS+1)'(1);

    if (cnt > {1'b0, llim}) begin
      fail = 1'b1;
      code = rrf_pkg::ST_TOO_LONG;
    end else begin
      byte_cnt_next = cnt[FRAME_LEN_BITS-1:0];
      case (p)
        PH_LINE: begin
          if (b == rrf_pkg::CHR_CR) phase_next = PH_LINE_LF;
        end
        PH_LINE_LF: begin
          if (b != rrf_pkg::CHR_LF) begin
            fail = 1'b1; code = rrf_pkg::ST_NO_CRLF;
          end else begin
            done = 1'b1;
          end
        end
        PH_HDR0, PH_HDR: begin
          if (p == PH_HDR0 && (b == rrf_pkg::CHR_MINUS || b == rrf_pkg::CHR_PLUS)) begin
            neg_sign_next = (b == rrf_pkg::CHR_MINUS);
            phase_next    = PH_HDR;
          end else if (is_digit) begin
            if (v > VW'(nlim)) begin
              if (!ng) begin
                fail = 1'b1; code = rrf_pkg::ST_TOO_LONG;
              end else begin
                // negative magnitude saturates just above the limit
                num_value_next   = nlim + NUM_BITS'(1);
                digits_seen_next = 1'b1;
                phase_next       = PH_HDR;
              end
            end else begin
              num_value_next   = v[NUM_BITS-1:0];
              digits_seen_next = 1'b1;
              phase_next       = PH_HDR;
            end
          end else if (b == rrf_pkg::CHR_CR && dg) begin
            phase_next = PH_HDR_LF;
          end else begin
            fail = 1'b1; code = rrf_pkg::ST_BAD_NUM;
          end
        end
        PH_HDR_LF: begin
          if (b != rrf_pkg::CHR_LF) begin
            fail = 1'b1; code = rrf_pkg::ST_NO_CRLF;
          end else if (k == rrf_pkg::KIND_BULK || el != '0) begin
            // bulk reply or array element header
            if (ng) begin
              if (k == rrf_pkg::KIND_BULK && nv == NUM_BITS'(1)) begin
                done = 1'b1;
              end else begin
                fail = 1'b1;
                code = (k != rrf_pkg::KIND_BULK && nv == NUM_BITS'(1)) ?
                       rrf_pkg::ST_NIL_ELEM : rrf_pkg::ST_BAD_NUM;
              end
            end else begin
              payload_left_next = nv;
              neg_sign_next     = 1'b0;
              num_value_next    = '0;
              digits_seen_next  = 1'b0;
              phase_next        = (nv != '0) ? PH_PAYLOAD : PH_DATA_CR;
            end
          end else begin
            // array count header
            if (ng || nv == '0) begin
              done = 1'b1;
            end else begin
              elems_left_next  = nv;
              neg_sign_next    = 1'b0;
              num_value_next   = '0;
              digits_seen_next = 1'b0;
              phase_next       = PH_ELEM_TYPE;
            end
          end
        end
        PH_ELEM_TYPE: begin
          if (b != rrf_pkg::CHR_DOLLAR) begin
            fail = 1'b1; code = rrf_pkg::ST_NO_DOLLAR;
          end else begin
            neg_sign_next    = 1'b0;
            num_value_next   = '0;
            digits_seen_next = 1'b0;
            phase_next       = PH_HDR0;
          end
        end
        PH_PAYLOAD: begin
          payload_left_next = pl - NUM_BITS'(1);
          if (pl == NUM_BITS'(1)) phase_next = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (b != rrf_pkg::CHR_CR) begin
            fail = 1'b1; code = rrf_pkg::ST_NO_CRLF;
          end else begin
            phase_next = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (b != rrf_pkg::CHR_LF) begin
            fail = 1'b1; code = rrf_pkg::ST_NO_CRLF;
          end else if (k == rrf_pkg::KIND_BULK || el == NUM_BITS'(1)) begin
            done = 1'b1;
          end else begin
            elems_left_next = el - NUM_BITS'(1);
            phase_next      = PH_ELEM_TYPE;
          end
        end
        default: begin
          // idle: type byte
          neg_sign_next    = 1'b0;
          num_value_next   = '0;
          digits_seen_next = 1'b0;
          if (b == rrf_pkg::CHR_PLUS) begin
            cur_kind_next = rrf_pkg::KIND_STATUS;  phase_next = PH_LINE;
          end else if (b == rrf_pkg::CHR_MINUS) begin
            cur_kind_next = rrf_pkg::KIND_ERROR;   phase_next = PH_LINE;
          end else if (b == rrf_pkg::CHR_COLON) begin
            cur_kind_next = rrf_pkg::KIND_INTEGER; phase_next = PH_LINE;
          end else if (b == rrf_pkg::CHR_DOLLAR) begin
            cur_kind_next = rrf_pkg::KIND_BULK;    phase_next = PH_HDR0;
          end else if (b == rrf_pkg::CHR_STAR) begin
            cur_kind_next   = rrf_pkg::KIND_ARRAY; phase_next = PH_HDR0;
            elems_left_next = '0;
          end else begin
            fail = 1'b1; code = rrf_pkg::ST_BAD_TYPE;
          end
        end
      endcase
    end

    len_w            = LW'(cnt[FRAME_LEN_BITS-1:0]);
    res_valid        = fail || done;
    res.status       = fail ? code : rrf_pkg::ST_OK;
    res.frame_length = done ? len_w[rrf_pkg::LEN_W-1:0] : '0;
    res.reply_kind   = k;

    // every result ends the frame
    if (res_valid) begin
      phase_next        = PH_IDLE;
      cur_kind_next     = rrf_pkg::KIND_STATUS;
      neg_sign_next     = 1'b0;
      num_value_next    = '0;
      digits_seen_next  = 1'b0;
      payload_left_next = '0;
      elems_left_next   = '0;
      byte_cnt_next     = '0;
    end
  end

  // Parser state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cur_kind      <= rrf_pkg::KIND_STATUS;
      neg_sign      <= 1'b0;
      num_value     <= '0;
      digits_seen   <= 1'b0;
      payload_left  <= '0;
      elems_left    <= '0;
      byte_cnt      <= '0;
      max_frame_len <= rrf_pkg::MAX_LEN_RESET;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        cur_kind     <= cur_kind_next;
        neg_sign     <= neg_sign_next;
        num_value    <= num_value_next;
        digits_seen  <= digits_seen_next;
        payload_left <= payload_left_next;
        elems_left   <= elems_left_next;
        byte_cnt     <= byte_cnt_next;
      end
      if (cfg.valid && cfg.ready) max_frame_len <= cfg.data;
    end
  end

  // Output register with skid word: a result lands in the skid word only when
  // the output register is held by a stalled word; bytes stop while it is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_word  <= res;
        skid_valid <= 1'b1;
      end else begin
        out_word  <= res;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign bytes.ready  = !skid_valid;
  assign frames.valid = out_valid;
  assign frames.data  = out_word;
  assign cfg.ready    = 1'b1;

endmodule

// ===== rtl/core/rrf_checker.sv =====
// Port-level checks on the reply framer's result channel, bound to the top.
// Depends on rrf_pkg and resp_reply_framer_unit_macros.svh.
`include "resp_reply_framer_unit_macros.svh"

module rrf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          valid,
  input logic                          ready,
  input logic [rrf_pkg::STATUS_W-1:0]  status,
  input logic [rrf_pkg::LEN_W-1:0]     frame_length,
  input logic [rrf_pkg::KIND_W-1:0]    reply_kind
);

  // errors carry no length
  `RRF_ASSERT_IMP(a_err_len_zero, valid && status != rrf_pkg::ST_OK, frame_length == '0)
  // shortest good frame is a type byte plus CR LF
  `RRF_ASSERT_IMP(a_ok_len_min, valid && status == rrf_pkg::ST_OK, frame_length >= 3)
  // a bad type byte never names a kind
  `RRF_ASSERT_IMP(a_bad_type_kind, valid && status == rrf_pkg::ST_BAD_TYPE,
                  reply_kind == rrf_pkg::KIND_STATUS)
  // only bulk and array frames can fail on headers
  `RRF_ASSERT_IMP(a_hdr_err_kind,
                  valid && (status == rrf_pkg::ST_BAD_NUM || status == rrf_pkg::ST_NO_DOLLAR ||
                            status == rrf_pkg::ST_NIL_ELEM),
                  reply_kind == rrf_pkg::KIND_BULK || reply_kind == rrf_pkg::KIND_ARRAY)
  // stalled word holds
  `RRF_ASSERT_NXT(a_out_hold, valid && !ready,
                  valid && $stable({status, frame_length, reply_kind}))

endmodule

bind resp_reply_framer_unit rrf_checker u_rrf_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (frames.valid),
  .ready        (frames.ready),
  .status       (frames.data.status),
  .frame_length (frames.data.frame_length),
  .reply_kind   (frames.data.reply_kind)
);
